/* src/rsi_pkg.sv */
// Shared types and widths for the ray / sphere intersection pipeline.
// No dependencies; used by every module under src.
package rsi_pkg;

    // Internal widths, sized to the exact ranges of the quadratic terms
    localparam int IN_W    = 32;   // coordinate width
    localparam int RAD_W   = 31;   // radius width
    localparam int OC_W    = 33;   // origin minus centre
    localparam int A_W     = 64;   // d.d, unsigned
    localparam int BH_W    = 66;   // oc.d, signed (B is twice this)
    localparam int C_W     = 67;   // oc.oc - r*r, signed
    localparam int MAG_W   = 66;   // magnitude of oc.d and of C
    localparam int SQ_W    = 132;  // B*B/4 and A*|C|
    localparam int E_W     = 133;  // B*B/4 - A*C, signed
    localparam int DMAG_W  = 134;  // positive discriminant
    localparam int ROOT_W  = 67;   // integer square root of the discriminant
    localparam int R_W     = 135;  // square root remainder
    localparam int NUM_W   = 69;   // -B - sqrt(D), signed
    localparam int QB      = 32;   // quotient bits produced by the divider
    localparam int DEN_W   = A_W + 1;

    localparam logic [IN_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0] DIST_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [IN_W-1:0] ox;
        logic signed [IN_W-1:0] oy;
        logic signed [IN_W-1:0] oz;
        logic signed [IN_W-1:0] dx;
        logic signed [IN_W-1:0] dy;
        logic signed [IN_W-1:0] dz;
        logic signed [IN_W-1:0] cx;
        logic signed [IN_W-1:0] cy;
        logic signed [IN_W-1:0] cz;
        logic [RAD_W-1:0]       r;
    } rsi_ray_t;

    // Sideband carried alongside the square root
    typedef struct packed {
        logic                   hit;
        logic signed [BH_W-1:0] bh;
        logic [A_W-1:0]         a;
    } rsi_side_t;

    // Sideband carried alongside the divider
    typedef struct packed {
        logic             hit;
        logic             neg;
        logic             big;
        logic [DEN_W-1:0] den;
    } rsi_qside_t;

endpackage

/* src/rsi_front.sv */
// Front end: forms A, B/2, C and the discriminant over seven register stages.
// Depends on rsi_pkg.
module rsi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  rsi_pkg::rsi_ray_t             in_ray,
    output logic                          out_valid,
    output logic [rsi_pkg::DMAG_W-1:0]    out_dmag,
    output rsi_pkg::rsi_side_t            out_side
);

    localparam int NST = 7;

    logic [NST-1:0] valid_reg;

    // stage 1
    logic signed [rsi_pkg::OC_W-1:0] oc_next [3];
    logic signed [rsi_pkg::OC_W-1:0] oc_reg  [3];
    logic signed [rsi_pkg::IN_W-1:0] d_reg   [3];
    logic [rsi_pkg::RAD_W-1:0]       r_reg;
    // stage 2
    logic signed [63:0] dd_next [3];
    logic signed [63:0] dd_reg  [3];
    logic signed [64:0] ocd_next [3];
    logic signed [64:0] ocd_reg  [3];
    logic signed [65:0] ococ_next [3];
    logic signed [65:0] ococ_reg  [3];
    logic [61:0]        rr_next, rr_reg;
    // stage 3
    logic [rsi_pkg::A_W-1:0]         a_next, a_reg;
    logic signed [rsi_pkg::BH_W-1:0] bh_next, bh_reg;
    logic signed [rsi_pkg::C_W-1:0]  c_next, c_reg;
    // stage 4
    logic [rsi_pkg::MAG_W-1:0] bm_next, bm_reg, cm_next, cm_reg;
    logic                      cneg_next, cneg4_reg;
    rsi_pkg::rsi_side_t        side4_reg;
    // stage 5
    logic [65:0] bhh_next, bhh_reg, bhl_next, bhl_reg, bll_next, bll_reg;
    logic [64:0] phh_next, phh_reg, phl_next, phl_reg, plh_next, plh_reg, pll_next, pll_reg;
    logic        cneg5_reg;
    rsi_pkg::rsi_side_t side5_reg;
    // stage 6
    logic [rsi_pkg::SQ_W-1:0] bsq_next, bsq_reg, ac_next, ac_reg;
    logic                     cneg6_reg;
    rsi_pkg::rsi_side_t       side6_reg;
    // stage 7
    logic signed [rsi_pkg::E_W-1:0] e_next;
    logic                           dpos_next;
    logic [rsi_pkg::DMAG_W-1:0]     dmag_next, dmag_reg;
    rsi_pkg::rsi_side_t             side7_reg;

    // Offset of the origin from the centre
    always_comb
    begin
        oc_next[0] = rsi_pkg::OC_W'(in_ray.ox) - rsi_pkg::OC_W'(in_ray.cx);
        oc_next[1] = rsi_pkg::OC_W'(in_ray.oy) - rsi_pkg::OC_W'(in_ray.cy);
        oc_next[2] = rsi_pkg::OC_W'(in_ray.oz) - rsi_pkg::OC_W'(in_ray.cz);
    end

    // Per-axis products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd_next[i]   = 64'(d_reg[i]) * 64'(d_reg[i]);
            ocd_next[i]  = 65'(oc_reg[i]) * 65'(d_reg[i]);
            ococ_next[i] = 66'(oc_reg[i]) * 66'(oc_reg[i]);
        end
        rr_next = 62'(r_reg) * 62'(r_reg);
    end

    // Dot products and C
    always_comb
    begin
        a_next  = 64'(dd_reg[0]) + 64'(dd_reg[1]) + 64'(dd_reg[2]);
        bh_next = 66'(ocd_reg[0]) + 66'(ocd_reg[1]) + 66'(ocd_reg[2]);
        c_next  = 67'(ococ_reg[0]) + 67'(ococ_reg[1]) + 67'(ococ_reg[2]) - 67'(rr_reg);
    end

    // Magnitudes for the wide products
    always_comb
    begin
        bm_next   = bh_reg[rsi_pkg::BH_W-1] ? rsi_pkg::MAG_W'(-bh_reg)
                                            : rsi_pkg::MAG_W'(bh_reg);
        cneg_next = c_reg[rsi_pkg::C_W-1];
        cm_next   = cneg_next ? rsi_pkg::MAG_W'(-c_reg) : rsi_pkg::MAG_W'(c_reg);
    end

    // Partial products of (B/2)^2 and A*|C|
    always_comb
    begin
        bhh_next = 66'(bm_reg[65:33]) * 66'(bm_reg[65:33]);
        bhl_next = 66'(bm_reg[65:33]) * 66'(bm_reg[32:0]);
        bll_next = 66'(bm_reg[32:0]) * 66'(bm_reg[32:0]);
        phh_next = 65'(side4_reg.a[63:32]) * 65'(cm_reg[65:33]);
        phl_next = 65'(side4_reg.a[63:32]) * 65'(cm_reg[32:0]);
        plh_next = 65'(side4_reg.a[31:0]) * 65'(cm_reg[65:33]);
        pll_next = 65'(side4_reg.a[31:0]) * 65'(cm_reg[32:0]);
    end

    // Recombine the partial products
    always_comb
    begin
        bsq_next = (rsi_pkg::SQ_W'(bhh_reg) << 66) + (rsi_pkg::SQ_W'(bhl_reg) << 34)
                 + rsi_pkg::SQ_W'(bll_reg);
        ac_next  = (rsi_pkg::SQ_W'(phh_reg) << 65) + (rsi_pkg::SQ_W'(phl_reg) << 32)
                 + (rsi_pkg::SQ_W'(plh_reg) << 33) + rsi_pkg::SQ_W'(pll_reg);
    end

    // Discriminant D = 4 * ((B/2)^2 - A*C)
    always_comb
    begin
        e_next    = cneg6_reg ? rsi_pkg::E_W'(bsq_reg) + rsi_pkg::E_W'(ac_reg)
                              : rsi_pkg::E_W'(bsq_reg) - rsi_pkg::E_W'(ac_reg);
        dpos_next = !e_next[rsi_pkg::E_W-1] && (e_next != '0) && (side6_reg.a != '0);
        dmag_next = dpos_next ? {e_next[rsi_pkg::E_W-2:0], 2'b00} : '0;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NST-2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oc_reg   <= oc_next;
            d_reg[0] <= in_ray.dx;
            d_reg[1] <= in_ray.dy;
            d_reg[2] <= in_ray.dz;
            r_reg    <= in_ray.r;

            dd_reg   <= dd_next;
            ocd_reg  <= ocd_next;
            ococ_reg <= ococ_next;
            rr_reg   <= rr_next;

            a_reg  <= a_next;
            bh_reg <= bh_next;
            c_reg  <= c_next;

            bm_reg        <= bm_next;
            cm_reg        <= cm_next;
            cneg4_reg     <= cneg_next;
            side4_reg.hit <= 1'b0;
            side4_reg.bh  <= bh_reg;
            side4_reg.a   <= a_reg;

            bhh_reg   <= bhh_next;
            bhl_reg   <= bhl_next;
            bll_reg   <= bll_next;
            phh_reg   <= phh_next;
            phl_reg   <= phl_next;
            plh_reg   <= plh_next;
            pll_reg   <= pll_next;
            cneg5_reg <= cneg4_reg;
            side5_reg <= side4_reg;

            bsq_reg   <= bsq_next;
            ac_reg    <= ac_next;
            cneg6_reg <= cneg5_reg;
            side6_reg <= side5_reg;

            dmag_reg      <= dmag_next;
            side7_reg.hit <= dpos_next;
            side7_reg.bh  <= side6_reg.bh;
            side7_reg.a   <= side6_reg.a;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_dmag  = dmag_reg;
    assign out_side  = side7_reg;

endmodule

/* src/rsi_sqrt.sv */
// Integer square root, one result bit per register stage.
// Depends on rsi_pkg.
module rsi_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [rsi_pkg::DMAG_W-1:0]    in_dmag,
    input  rsi_pkg::rsi_side_t            in_side,
    output logic                          out_valid,
    output logic [rsi_pkg::ROOT_W-1:0]    out_root,
    output rsi_pkg::rsi_side_t            out_side
);

    localparam int NS = rsi_pkg::ROOT_W;

    logic [rsi_pkg::R_W-1:0]    rem_reg  [NS];
    logic [rsi_pkg::ROOT_W-1:0] root_reg [NS];
    rsi_pkg::rsi_side_t         side_reg [NS];
    logic [NS-1:0]              valid_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        localparam int K = NS - 1 - i;

        logic [rsi_pkg::R_W-1:0]    rem_in, trial, rem_next;
        logic [rsi_pkg::ROOT_W-1:0] root_in, root_next;
        rsi_pkg::rsi_side_t         side_in;
        logic                       valid_in;

        if (i == 0)
        begin : g_first
            assign rem_in   = rsi_pkg::R_W'(in_dmag);
            assign root_in  = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end
        else
        begin : g_chain
            assign rem_in   = rem_reg[i-1];
            assign root_in  = root_reg[i-1];
            assign side_in  = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        // Try setting root bit K: (x + 2^K)^2 - x^2 = x*2^(K+1) + 2^(2K)
        always_comb
        begin
            trial = (rsi_pkg::R_W'(root_in) << (K + 1)) | (rsi_pkg::R_W'(1) << (2 * K));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (rsi_pkg::ROOT_W'(1) << K);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

/* src/rsi_div.sv */
// Numerator forming, restoring divider and saturation of the nearer root.
// Depends on rsi_pkg.
module rsi_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [rsi_pkg::ROOT_W-1:0]    in_root,
    input  rsi_pkg::rsi_side_t            in_side,
    output logic                          out_valid,
    output logic                          out_hit,
    output logic [rsi_pkg::IN_W-1:0]      out_dist
);

    localparam int MAGN_W = rsi_pkg::NUM_W - 1;
    localparam int NS_W   = MAGN_W + FRAC_BITS;
    localparam int QR_W   = rsi_pkg::DEN_W + rsi_pkg::QB;
    localparam int CMP_W  = (NS_W > QR_W) ? NS_W : QR_W;
    localparam int NQ     = rsi_pkg::QB;

    localparam logic [rsi_pkg::IN_W-1:0] MISS_DIST =
        ~((rsi_pkg::IN_W'(1) << FRAC_BITS) - rsi_pkg::IN_W'(1));

    // numerator stage
    logic signed [rsi_pkg::NUM_W-1:0] num_next, num_reg;
    rsi_pkg::rsi_side_t               nside_reg;
    logic                             nvalid_reg;
    // magnitude stage
    logic [MAGN_W-1:0]  mag_next, mag_reg;
    rsi_pkg::rsi_qside_t mside_reg;
    logic               mvalid_reg;
    // range check stage
    logic [CMP_W-1:0]   ns_wide, den_top;
    logic               big_next;
    logic [QR_W-1:0]    rem0_reg;
    rsi_pkg::rsi_qside_t qside0_reg;
    logic               qvalid0_reg;
    // divider stages
    logic [QR_W-1:0]          rem_reg  [NQ];
    logic [rsi_pkg::QB-1:0]   quo_reg  [NQ];
    rsi_pkg::rsi_qside_t      qside_reg [NQ];
    logic [NQ-1:0]            qvalid_reg;
    // output stage
    logic [rsi_pkg::IN_W-1:0] dist_next, dist_reg;
    logic                     hit_reg, neg_reg, ovalid_reg;
    rsi_pkg::rsi_qside_t      last_side;
    logic [rsi_pkg::QB-1:0]   last_quo;

    // -B - sqrt(D), with B = 2 * bh
    always_comb
    begin
        num_next = rsi_pkg::NUM_W'(0) - (rsi_pkg::NUM_W'(in_side.bh) << 1)
                 - rsi_pkg::NUM_W'(in_root);
    end

    // Sign and magnitude of the numerator
    always_comb
    begin
        mag_next = num_reg[rsi_pkg::NUM_W-1] ? MAGN_W'(-num_reg) : MAGN_W'(num_reg);
    end

    // Quotients of 2^32 and above saturate
    always_comb
    begin
        ns_wide  = CMP_W'(mag_reg) << FRAC_BITS;
        den_top  = CMP_W'(mside_reg.den) << rsi_pkg::QB;
        big_next = (ns_wide >= den_top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nvalid_reg  <= 1'b0;
            mvalid_reg  <= 1'b0;
            qvalid0_reg <= 1'b0;
        end
        else if (en)
        begin
            nvalid_reg  <= in_valid;
            mvalid_reg  <= nvalid_reg;
            qvalid0_reg <= mvalid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg   <= num_next;
            nside_reg <= in_side;

            mag_reg       <= mag_next;
            mside_reg.hit <= nside_reg.hit;
            mside_reg.neg <= num_reg[rsi_pkg::NUM_W-1];
            mside_reg.big <= 1'b0;
            mside_reg.den <= {nside_reg.a, 1'b0};

            rem0_reg       <= QR_W'(ns_wide);
            qside0_reg.hit <= mside_reg.hit;
            qside0_reg.neg <= mside_reg.neg;
            qside0_reg.big <= big_next;
            qside0_reg.den <= mside_reg.den;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar i = 0; i < NQ; i++)
    begin : g_qstage
        localparam int K = NQ - 1 - i;

        logic [QR_W-1:0]        rem_in, sub, rem_next;
        logic [rsi_pkg::QB-1:0] quo_in, quo_next;
        rsi_pkg::rsi_qside_t    side_in;
        logic                   valid_in;

        if (i == 0)
        begin : g_first
            assign rem_in   = rem0_reg;
            assign quo_in   = '0;
            assign side_in  = qside0_reg;
            assign valid_in = qvalid0_reg;
        end
        else
        begin : g_chain
            assign rem_in   = rem_reg[i-1];
            assign quo_in   = quo_reg[i-1];
            assign side_in  = qside_reg[i-1];
            assign valid_in = qvalid_reg[i-1];
        end

        always_comb
        begin
            sub = QR_W'(side_in.den) << K;
            if (rem_in >= sub)
            begin
                rem_next = rem_in - sub;
                quo_next = quo_in | (rsi_pkg::QB'(1) << K);
            end
            else
            begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qvalid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                qvalid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]   <= rem_next;
                quo_reg[i]   <= quo_next;
                qside_reg[i] <= side_in;
            end
        end
    end

    assign last_side = qside_reg[NQ-1];
    assign last_quo  = quo_reg[NQ-1];

    // Apply sign, saturate, substitute the miss value
    always_comb
    begin
        if (!last_side.hit)
        begin
            dist_next = MISS_DIST;
        end
        else if (!last_side.neg)
        begin
            dist_next = (last_side.big || last_quo[rsi_pkg::QB-1]) ? rsi_pkg::DIST_MAX
                                                                    : last_quo;
        end
        else if (last_side.big || (last_quo > rsi_pkg::DIST_MIN))
        begin
            dist_next = rsi_pkg::DIST_MIN;
        end
        else
        begin
            dist_next = rsi_pkg::IN_W'(0) - last_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (en)
        begin
            ovalid_reg <= qvalid_reg[NQ-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
            hit_reg  <= last_side.hit;
            neg_reg  <= last_side.neg;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_hit   = hit_reg;
    assign out_dist  = dist_reg;

`ifndef SYNTHESIS
    // A hit in front of the origin never reports a negative distance
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && hit_reg && !neg_reg |-> !dist_reg[rsi_pkg::IN_W-1])
        else $error("positive root reported negative");

    // A hit behind the origin never reports a positive distance
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && hit_reg && neg_reg |-> (dist_reg[rsi_pkg::IN_W-1] || dist_reg == '0))
        else $error("negative root reported positive");
`endif

endmodule

/* src/ray_sphere_intersect.sv */
// Top level of the ray / sphere intersection pipeline.
// Depends on rsi_pkg, rsi_front, rsi_sqrt and rsi_div.
//
// Usage:
//   Slave channel s_*: one beat per ray/sphere pair. Master channel m_*:
//   one beat per input beat, in the same order, carrying the hit flag in
//   m_tuser and the nearer intersection distance in m_tdata.
//   A miss (discriminant <= 0 or direction zero) returns distance -1.0.
// Stages: seven front-end stages, 67 square root stages (one root bit
//   each), three numerator and range-check stages, 32 divider stages
//   (one quotient bit each) and the output register.
// Throughput: one beat per cycle when not stalled; all stages registered.
// Reset: rst_n clears all valid bits at once; the pipeline is empty and
//   ready once reset is released.
// Stall: when m_tvalid is high and m_tready low, the whole pipeline holds
//   and s_tready drops; no beat is lost or repeated, and bubbles inside
//   the pipeline are filled by fresh input while the output waits is not
//   attempted: the pipeline advances as one.
module ray_sphere_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ray_origin_x/y/z, ray_dir_x/y/z, sphere_center_x/y/z (32 each),
    // sphere_radius (31), one zero pad bit at the top
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_distance (32)
    output logic [31:0]  m_tdata,
    // hit (1)
    output logic         m_tuser
);

    logic                             en;
    rsi_pkg::rsi_ray_t                ray;
    logic                             f_valid;
    logic [rsi_pkg::DMAG_W-1:0]       f_dmag;
    rsi_pkg::rsi_side_t               f_side;
    logic                             q_valid;
    logic [rsi_pkg::ROOT_W-1:0]       q_root;
    rsi_pkg::rsi_side_t               q_side;

    // Advance the whole pipeline unless a result waits
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Unpack the input beat
    always_comb
    begin
        ray.ox = s_tdata[31:0];
        ray.oy = s_tdata[63:32];
        ray.oz = s_tdata[95:64];
        ray.dx = s_tdata[127:96];
        ray.dy = s_tdata[159:128];
        ray.dz = s_tdata[191:160];
        ray.cx = s_tdata[223:192];
        ray.cy = s_tdata[255:224];
        ray.cz = s_tdata[287:256];
        ray.r  = s_tdata[318:288];
    end

    rsi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid && s_tready),
        .in_ray   (ray),
        .out_valid(f_valid),
        .out_dmag (f_dmag),
        .out_side (f_side)
    );

    rsi_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .in_dmag  (f_dmag),
        .in_side  (f_side),
        .out_valid(q_valid),
        .out_root (q_root),
        .out_side (q_side)
    );

    rsi_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (q_valid),
        .in_root  (q_root),
        .in_side  (q_side),
        .out_valid(m_tvalid),
        .out_hit  (m_tuser),
        .out_dist (m_tdata)
    );

`ifndef SYNTHESIS
    // A waiting result blocks new input
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // A miss always carries minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            m_tdata == ~((32'd1 << FRAC_BITS) - 32'd1))
        else $error("miss without minus one distance");
`endif

endmodule

/* tb/ray_sphere_intersect_tb.sv */
// Self-checking bench for the ray / sphere intersection pipeline.
// Depends on rsi_pkg and ray_sphere_intersect; predicts each beat with exact wide arithmetic.
module ray_sphere_intersect_tb;

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
    } hit_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;

    logic [319:0] pending_rays[$];
    hit_result_t  expected_hits[$];
    int           errors;
    int           burst_left;
    int           gap_left;
    int           cyc;
    int           holdoff_left;

    ray_sphere_intersect u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Queue one beat for the sender
    function automatic void add_ray(input logic [319:0] beat);
        pending_rays.insert(pending_rays.size(), beat);
    endfunction

    // Floor square root of a non-negative wide value
    function automatic logic [191:0] floor_root(input logic [191:0] v);
        logic [191:0] x;
        logic [191:0] cand;
        x = '0;
        for (int k = 70; k >= 0; k--)
        begin
            cand = x | (192'd1 << k);
            if (cand * cand <= v)
                x = cand;
        end
        return x;
    endfunction

    // Nearer intersection parameter of one ray / sphere pair
    function automatic hit_result_t nearest_hit(input logic [319:0] beat);
        logic signed [191:0] o[3];
        logic signed [191:0] d[3];
        logic signed [191:0] oc[3];
        logic signed [191:0] rad;
        logic signed [191:0] qa;
        logic signed [191:0] qb;
        logic signed [191:0] qc;
        logic signed [191:0] disc;
        logic signed [191:0] num;
        logic [191:0]        mag;
        logic [191:0]        den;
        logic [191:0]        quo;
        logic                neg;
        hit_result_t         res;
        qa = '0;
        qb = '0;
        qc = '0;
        for (int i = 0; i < 3; i++)
        begin
            o[i]  = $signed(beat[32*i +: 32]);
            d[i]  = $signed(beat[32*(3+i) +: 32]);
            oc[i] = o[i] - $signed(beat[32*(6+i) +: 32]);
            qa = qa + d[i] * d[i];
            qb = qb + oc[i] * d[i];
            qc = qc + oc[i] * oc[i];
        end
        rad  = $signed({161'd0, beat[288 +: 31]});
        qb   = qb * 2;
        qc   = qc - rad * rad;
        disc = qb * qb - 4 * qa * qc;
        // Miss: discriminant not positive or zero direction
        if (disc <= 0 || qa == 0)
        begin
            res.hit      = 1'b0;
            res.distance = 32'hFFFF_FFFF << 16;
            return res;
        end
        num = -qb - $signed(floor_root(disc));
        neg = num < 0;
        mag = neg ? -num : num;
        mag = mag << 16;
        den = qa << 1;
        quo = mag / den;
        res.hit = 1'b1;
        if (!neg)
            res.distance = (quo > 192'h7FFF_FFFF) ? rsi_pkg::DIST_MAX : quo[31:0];
        else
            res.distance = (quo > 192'h8000_0000) ? rsi_pkg::DIST_MIN
                                                  : (~quo[31:0] + 32'd1);
        return res;
    endfunction

    function automatic logic [319:0] pack_ray(
        input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
        input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
        input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
        input logic [30:0] r);
        return {1'b0, r, cz, cy, cx, dz, dy, dx, oz, oy, ox};
    endfunction

    // Small signed coordinate within +/- lim whole units, random fraction
    function automatic logic [31:0] near_coord(input int lim);
        return $urandom_range(0, 2 * lim * 65536) - lim * 65536;
    endfunction

    // Sender: bursts with random gaps, predict each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_hits.insert(expected_hits.size(), nearest_hit(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_rays.size() > 0)
                begin
                    s_tdata  <= pending_rays.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left <= 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, quiet stretches and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            cyc          <= 0;
            holdoff_left <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (cyc == 1000)
            begin
                holdoff_left <= 400;
                m_tready     <= 1'b0;
            end
            else if (holdoff_left > 0)
            begin
                holdoff_left <= holdoff_left - 1;
                m_tready     <= (holdoff_left == 1);
            end
            else if ((cyc / 300) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 9) > 2);
        end
    end

    // Monitor: compare each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected beat hit=%0b distance=%h", $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                hit_result_t exp_r;
                exp_r = expected_hits.pop_front();
                if (exp_r.hit !== m_tuser)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, m_tuser);
                    errors++;
                end
                if (exp_r.distance !== m_tdata)
                begin
                    $display("%0t: distance expected %h actual %h",
                             $time, exp_r.distance, m_tdata);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        do
            @(negedge clk);
        while (pending_rays.size() > 0 || s_tvalid || expected_hits.size() > 0);
    endtask

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        clk    = 1'b0;
        rst_n  = 1'b0;
        errors = 0;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;

        // Directed: zero direction, plain hit, start inside, extremes, saturation
        add_ray(pack_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 31'd0));
        add_ray(pack_ray(0, 0, 0, 0, 0, 0, 32'h0005_0000, 0, 0, 31'h0001_0000));
        add_ray(pack_ray(0, 0, 0, 0, 0, 32'h0001_0000,
                         0, 0, 32'h0005_0000, 31'h0001_0000));
        add_ray(pack_ray(0, 0, 0, 0, 0, 32'hFFFF_0000,
                         0, 0, 32'h0005_0000, 31'h0001_0000));
        add_ray(pack_ray(0, 0, 0, 0, 0, 32'h0001_0000,
                         0, 0, 0, 31'h0002_0000));
        add_ray(pack_ray(0, 0, 0, 32'h0001_0000, 0, 0,
                         0, 32'h0005_0000, 0, 31'h0001_0000));
        add_ray(pack_ray(0, 0, 0, 0, 0, 32'h0000_0001,
                         0, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        add_ray(pack_ray(0, 0, 0, 0, 0, 32'h0000_0001,
                         0, 0, 32'h8000_0000, 31'h7FFF_FFFF));
        add_ray(pack_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         31'h7FFF_FFFF));
        add_ray(pack_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         31'h7FFF_FFFF));
        add_ray(pack_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         31'h7FFF_FFFF));
        add_ray(pack_ray(0, 0, 0, 32'h7FFF_FFFF, 0, 0,
                         32'h0000_0001, 0, 0, 31'h0000_0001));
        add_ray(pack_ray(0, 0, 0, 32'h0001_0000, 0, 0,
                         32'h0001_0000, 32'h0001_0000, 0, 31'h0001_0000));
        // Hold the sender until every result is back
        drain();

        // Random: mostly aimed rays with small coordinates, some raw noise
        for (int n = 0; n < 1200; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                add_ray({1'b0, 31'($urandom()), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom()});
            else
            begin
                cx = near_coord(100);
                cy = near_coord(100);
                cz = near_coord(100);
                ox = near_coord(100);
                oy = near_coord(100);
                oz = near_coord(100);
                add_ray(pack_ray(ox, oy, oz,
                    cx - ox + near_coord(4), cy - oy + near_coord(4), cz - oz + near_coord(4),
                    cx, cy, cz, 31'($urandom_range(0, 30 * 65536))));
            end
        end
        drain();
        repeat (200) @(negedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
